/* sv/running_min_max_mean_variance_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the running statistics unit
// Concurrent checks that vanish when the code is synthesised.
// ----------------------------------------------------------------------------
`ifndef RUNNING_MIN_MAX_MEAN_VARIANCE_UNIT_ASSERT_SVH
`define RUNNING_MIN_MAX_MEAN_VARIANCE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted
`define RMMV_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define RMMV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define RMMV_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define RMMV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

/* sv/rmmv_pkg.sv */
// ----------------------------------------------------------------------------
// rmmv_pkg
// Widths, step lengths and sequencer states of the running statistics unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rmmv_pkg;

    // Field widths
    localparam int VALUE_W  = 32;
    localparam int COUNT_IN_W = 16;
    localparam int VAR_W    = 63;
    localparam int FRAC_W   = 16;

    // Bits of the sample count that take part (8 to 32)
    localparam int COUNT_W  = 16;

    // Datapath widths
    localparam int SQ_W     = VALUE_W + 1;
    localparam int ACC_W    = COUNT_W + 64;
    localparam int MPL_W    = (SQ_W > COUNT_W) ? SQ_W : COUNT_W;

    // Dividend lengths of the three divisions
    localparam int LEN_M    = COUNT_W + VALUE_W + 1;
    localparam int LEN_T    = COUNT_W + 49;
    localparam int LEN_V    = ACC_W;

    localparam int STEP_W   = $clog2(ACC_W + 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_S,
        ST_DIV_M,
        ST_DELTA,
        ST_SQR,
        ST_MUL_W,
        ST_DIV_T,
        ST_MUL_V,
        ST_DIV_V,
        ST_FIN
    } state_t;

endpackage

`default_nettype wire

/* sv/rmmv_sample_if.sv */
// ----------------------------------------------------------------------------
// rmmv_sample_if
// Valid/ready channel carrying one sample and its ordinal count.
// ----------------------------------------------------------------------------
`default_nettype none

interface rmmv_sample_if;

    logic                                 valid;
    logic                                 ready;
    logic signed [rmmv_pkg::VALUE_W-1:0]  sample_value;
    logic [rmmv_pkg::COUNT_IN_W-1:0]      sample_count;

    modport source (output valid, output sample_value, output sample_count, input ready);
    modport sink   (input valid, input sample_value, input sample_count, output ready);

endinterface

`default_nettype wire

/* sv/rmmv_stats_if.sv */
// ----------------------------------------------------------------------------
// rmmv_stats_if
// Valid/ready channel carrying the four running statistics.
// ----------------------------------------------------------------------------
`default_nettype none

interface rmmv_stats_if;

    logic                                 valid;
    logic                                 ready;
    logic signed [rmmv_pkg::VALUE_W-1:0]  min_value;
    logic signed [rmmv_pkg::VALUE_W-1:0]  max_value;
    logic signed [rmmv_pkg::VALUE_W-1:0]  mean_value;
    logic [rmmv_pkg::VAR_W-1:0]           variance_value;

    modport source (output valid, output min_value, output max_value, output mean_value,
                    output variance_value, input ready);
    modport sink   (input valid, input min_value, input max_value, input mean_value,
                    input variance_value, output ready);

endinterface

`default_nettype wire

/* sv/running_min_max_mean_variance_unit.sv */
// Sequence: counts 0 and 1 go from idle straight to ST_FIN, which waits for a free output
// register and loads it; count 2 or more first runs the phases ST_MUL_S to ST_DIV_V.
// Throughput: one sample per update, set by the shared bit-serial multiplier and the
// one-bit-per-cycle restoring divider; a new sample is taken while a result waits.
// Reset (rst_n low, asynchronous): min to most positive, max to most negative,
// mean and variance to zero, no result pending.
// ----------------------------------------------------------------------------
// running_min_max_mean_variance_unit
// Running minimum, maximum, mean and unbiased sample variance of Q16.16
// samples, built on a shift-add multiplier and a restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none
`include "running_min_max_mean_variance_unit_assert.svh"

module running_min_max_mean_variance_unit (
    input  wire logic          clk,
    input  wire logic          rst_n,
    rmmv_sample_if.sink        sample,
    rmmv_stats_if.source       stats
);

    localparam int ACC_W   = rmmv_pkg::ACC_W;
    localparam int COUNT_W = rmmv_pkg::COUNT_W;
    localparam int VALUE_W = rmmv_pkg::VALUE_W;
    localparam int VAR_W   = rmmv_pkg::VAR_W;
    localparam int MPL_W   = rmmv_pkg::MPL_W;
    localparam int SQ_W    = rmmv_pkg::SQ_W;
    localparam int STEP_W  = rmmv_pkg::STEP_W;

    rmmv_pkg::state_t state_reg, state_next;

    // Statistics
    logic signed [VALUE_W-1:0] min_reg, max_reg, mean_reg;
    logic [VAR_W-1:0]          var_reg;

    // Sample held for the update
    logic signed [VALUE_W-1:0] x_reg;
    logic [COUNT_W-1:0]        n_reg;

    // Serial datapath
    logic [ACC_W-1:0]          acc_reg;
    logic [ACC_W-1:0]          mcand_reg;
    logic [MPL_W-1:0]          mplier_reg;
    logic [COUNT_W-1:0]        rem_reg;
    logic [COUNT_W-1:0]        div_reg;
    logic [STEP_W-1:0]         cnt_reg;
    logic                      neg_reg;

    // Output register
    logic                      out_valid_reg;
    logic signed [VALUE_W-1:0] out_min_reg, out_max_reg, out_mean_reg;
    logic [VAR_W-1:0]          out_var_reg;

    logic                      in_xfer;
    logic                      out_free;
    logic [COUNT_W-1:0]        n_in;
    logic signed [VALUE_W-1:0] x_in;
    logic                      step_done;

    logic [ACC_W-1:0]          mul_sum;
    logic [COUNT_W:0]          rem_sh;
    logic [COUNT_W:0]          rem_diff;
    logic                      rem_ge;
    logic [ACC_W-1:0]          acc_abs;
    logic [VALUE_W-1:0]        mean_fix;
    logic [SQ_W-1:0]           delta;
    logic [SQ_W-1:0]           delta_abs;
    logic [VAR_W-1:0]          var_sat;

    assign n_in      = COUNT_W'(sample.sample_count);
    assign x_in      = sample.sample_value;
    assign in_xfer   = sample.valid && sample.ready;
    assign out_free  = !out_valid_reg || stats.ready;
    assign step_done = (cnt_reg == '0);

    // Shift-add step and restoring division step
    assign mul_sum   = acc_reg + (mplier_reg[0] ? mcand_reg : '0);
    assign rem_sh    = {rem_reg, acc_reg[ACC_W-1]};
    assign rem_diff  = rem_sh - {1'b0, div_reg};
    assign rem_ge    = (rem_sh >= {1'b0, div_reg});

    // Sign handling around the mean division and the delta
    assign acc_abs   = acc_reg[ACC_W-1] ? (~acc_reg + 1'b1) : acc_reg;
    assign mean_fix  = neg_reg ? (~acc_reg[VALUE_W-1:0] + 1'b1) : acc_reg[VALUE_W-1:0];
    assign delta     = {x_reg[VALUE_W-1], x_reg} - {mean_reg[VALUE_W-1], mean_reg};
    assign delta_abs = delta[SQ_W-1] ? (~delta + 1'b1) : delta;
    assign var_sat   = (|acc_reg[ACC_W-1:VAR_W]) ? {VAR_W{1'b1}} : acc_reg[VAR_W-1:0];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rmmv_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = (n_in >= COUNT_W'(2)) ? rmmv_pkg::ST_MUL_S : rmmv_pkg::ST_FIN;
                end
            end
            rmmv_pkg::ST_MUL_S: if (step_done) state_next = rmmv_pkg::ST_DIV_M;
            rmmv_pkg::ST_DIV_M: if (step_done) state_next = rmmv_pkg::ST_DELTA;
            rmmv_pkg::ST_DELTA: state_next = rmmv_pkg::ST_SQR;
            rmmv_pkg::ST_SQR:   if (step_done) state_next = rmmv_pkg::ST_MUL_W;
            rmmv_pkg::ST_MUL_W: if (step_done) state_next = rmmv_pkg::ST_DIV_T;
            rmmv_pkg::ST_DIV_T: if (step_done) state_next = rmmv_pkg::ST_MUL_V;
            rmmv_pkg::ST_MUL_V: if (step_done) state_next = rmmv_pkg::ST_DIV_V;
            rmmv_pkg::ST_DIV_V: if (step_done) state_next = rmmv_pkg::ST_FIN;
            rmmv_pkg::ST_FIN:   if (out_free) state_next = rmmv_pkg::ST_IDLE;
            default:            state_next = rmmv_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        sample.ready         = (state_reg == rmmv_pkg::ST_IDLE);
        stats.valid          = out_valid_reg;
        stats.min_value      = out_min_reg;
        stats.max_value      = out_max_reg;
        stats.mean_value     = out_mean_reg;
        stats.variance_value = out_var_reg;
    end

    // Advance the sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rmmv_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Hold the statistics and the result transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg       <= {1'b0, {(VALUE_W-1){1'b1}}};
            max_reg       <= {1'b1, {(VALUE_W-1){1'b0}}};
            mean_reg      <= '0;
            var_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // Raise valid as the result loads, drop it once transferred
            if (state_reg == rmmv_pkg::ST_FIN && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (stats.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                rmmv_pkg::ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        if (n_in == COUNT_W'(1))
                        begin
                            min_reg  <= x_in;
                            max_reg  <= x_in;
                            mean_reg <= x_in;
                            var_reg  <= '0;
                        end
                        else
                        begin
                            if (x_in < min_reg) min_reg <= x_in;
                            if (x_in > max_reg) max_reg <= x_in;
                        end
                    end
                end
                rmmv_pkg::ST_DIV_M:
                begin
                    if (step_done) mean_reg <= mean_fix;
                end
                rmmv_pkg::ST_DIV_V:
                begin
                    if (step_done) var_reg <= var_sat;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Load the output register
    always_ff @(posedge clk)
    begin
        if (state_reg == rmmv_pkg::ST_FIN && out_free)
        begin
            out_min_reg  <= min_reg;
            out_max_reg  <= max_reg;
            out_mean_reg <= mean_reg;
            out_var_reg  <= var_reg;
        end
    end

    // Serial multiply and divide: step while the count runs, set up the next phase at zero
    always_ff @(posedge clk)
    begin
        case (state_reg)
            rmmv_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    // s = (n-1)*mean + x, accumulated on top of x
                    x_reg      <= x_in;
                    n_reg      <= n_in;
                    acc_reg    <= {{(ACC_W-VALUE_W){x_in[VALUE_W-1]}}, x_in};
                    mcand_reg  <= {{(ACC_W-VALUE_W){mean_reg[VALUE_W-1]}}, mean_reg};
                    mplier_reg <= MPL_W'(n_in - COUNT_W'(1));
                    cnt_reg    <= STEP_W'(COUNT_W);
                end
            end
            rmmv_pkg::ST_MUL_S, rmmv_pkg::ST_SQR, rmmv_pkg::ST_MUL_W, rmmv_pkg::ST_MUL_V:
            begin
                if (!step_done)
                begin
                    acc_reg    <= mul_sum;
                    mcand_reg  <= {mcand_reg[ACC_W-2:0], 1'b0};
                    mplier_reg <= {1'b0, mplier_reg[MPL_W-1:1]};
                    cnt_reg    <= cnt_reg - 1'b1;
                end
                else
                begin
                    rem_reg <= '0;
                    case (state_reg)
                        rmmv_pkg::ST_MUL_S:
                        begin
                            // Divide |s| by n
                            neg_reg <= acc_reg[ACC_W-1];
                            acc_reg <= acc_abs << (ACC_W - rmmv_pkg::LEN_M);
                            div_reg <= n_reg;
                            cnt_reg <= STEP_W'(rmmv_pkg::LEN_M);
                        end
                        rmmv_pkg::ST_SQR:
                        begin
                            // Drop the low fraction bits, then scale by n
                            mcand_reg  <= {{rmmv_pkg::FRAC_W{1'b0}},
                                           acc_reg[ACC_W-1:rmmv_pkg::FRAC_W]};
                            acc_reg    <= '0;
                            mplier_reg <= MPL_W'(n_reg);
                            cnt_reg    <= STEP_W'(COUNT_W);
                        end
                        rmmv_pkg::ST_MUL_W:
                        begin
                            acc_reg <= acc_reg << (ACC_W - rmmv_pkg::LEN_T);
                            div_reg <= n_reg - COUNT_W'(1);
                            cnt_reg <= STEP_W'(rmmv_pkg::LEN_T);
                        end
                        default:
                        begin
                            acc_reg <= acc_reg << (ACC_W - rmmv_pkg::LEN_V);
                            div_reg <= n_reg - COUNT_W'(1);
                            cnt_reg <= STEP_W'(rmmv_pkg::LEN_V);
                        end
                    endcase
                end
            end
            rmmv_pkg::ST_DIV_M, rmmv_pkg::ST_DIV_T, rmmv_pkg::ST_DIV_V:
            begin
                if (!step_done)
                begin
                    rem_reg <= rem_ge ? rem_diff[COUNT_W-1:0] : rem_sh[COUNT_W-1:0];
                    acc_reg <= {acc_reg[ACC_W-2:0], rem_ge};
                    cnt_reg <= cnt_reg - 1'b1;
                end
                else if (state_reg == rmmv_pkg::ST_DIV_T)
                begin
                    // var*(n-2) accumulated on top of the inner term
                    mcand_reg  <= {{(ACC_W-VAR_W){1'b0}}, var_reg};
                    mplier_reg <= MPL_W'(n_reg - COUNT_W'(2));
                    cnt_reg    <= STEP_W'(COUNT_W);
                end
            end
            rmmv_pkg::ST_DELTA:
            begin
                // Square |x - mean|
                acc_reg    <= '0;
                mcand_reg  <= {{(ACC_W-SQ_W){1'b0}}, delta_abs};
                mplier_reg <= MPL_W'(delta_abs);
                cnt_reg    <= STEP_W'(SQ_W);
            end
            default:
            begin
            end
        endcase
    end

    // Checks
    `RMMV_ASSERT_NEXT(a_restart_clears, clk, rst_n,
        in_xfer && (n_in == COUNT_W'(1)),
        (var_reg == '0) && (mean_reg == $past(x_in)) && (state_reg == rmmv_pkg::ST_FIN),
        "restart did not load the sample and clear the variance")
    `RMMV_ASSERT_IMPL(a_min_le_max, clk, rst_n,
        state_reg == rmmv_pkg::ST_FIN,
        min_reg <= max_reg,
        "minimum above maximum at result time")
    `RMMV_ASSERT_IMPL(a_rem_below_div, clk, rst_n,
        (state_reg == rmmv_pkg::ST_DIV_M) || (state_reg == rmmv_pkg::ST_DIV_T) ||
            (state_reg == rmmv_pkg::ST_DIV_V),
        rem_reg < div_reg,
        "division remainder not below divisor")

endmodule

`default_nettype wire
